### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant checked at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

### src/lcsle_pkg.sv
package lcsle_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned LEN_OUT_W = 9;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STEP   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_LATE_LOAD = 2'd2
  } status_e;

  // Broadcast to every cell.
  typedef struct packed {
    logic            load;
    logic            clear;
    logic [CH_W-1:0] ch;
  } cell_ctrl_t;

  // Step byte travelling down the chain.
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
  } tok_t;

endpackage

### src/lcsle_cell.sv
`include "assert_macros.svh"

module lcsle_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 9,
  parameter int unsigned ROW_W = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcsle_pkg::cell_ctrl_t ctrl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  lcsle_pkg::tok_t       tok_i,
  input  logic [ROW_W-1:0]      diag_i,
  input  logic [ROW_W-1:0]      left_i,
  output lcsle_pkg::tok_t       tok_o,
  output logic [ROW_W-1:0]      diag_o,
  output logic [ROW_W-1:0]      left_o
);
  import lcsle_pkg::*;

  logic            active_q;
  logic [CH_W-1:0] b_q;
  logic [ROW_W-1:0] r_q;
  logic            tok_valid_q;
  logic [CH_W-1:0] tok_ch_q;
  logic [ROW_W-1:0] diag_q;
  logic [ROW_W-1:0] left_q;
  logic            hit;
  logic [ROW_W-1:0] v_d;

  always_comb begin
    hit = ctrl_i.load && (count_i == CNT_W'(IDX));
    if (b_q == tok_i.ch) begin
      v_d = diag_i + ROW_W'(1);
    end else if (r_q > left_i) begin
      v_d = r_q;
    end else begin
      v_d = left_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      tok_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        active_q <= 1'b0;
      end else if (hit) begin
        active_q <= 1'b1;
      end
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      b_q <= ctrl_i.ch;
      r_q <= '0;
    end else if (tok_i.valid && active_q) begin
      r_q <= v_d;
    end
    tok_ch_q <= tok_i.ch;
    // Columns past the loaded length pass the token through untouched.
    diag_q <= active_q ? r_q : diag_i;
    left_q <= active_q ? v_d : left_i;
  end

  assign tok_o  = '{valid: tok_valid_q, ch: tok_ch_q};
  assign diag_o = diag_q;
  assign left_o = left_q;

  `ASSERT_IMPLY(a_left_matches_row, clk_i, rst_ni, tok_valid_q && active_q, left_q == r_q, "cell output disagrees with stored row entry")

endmodule

### src/lcs_length_engine_unit.sv
// LCS length engine. Load the second string with kind-0 requests, then feed the
// first string with kind-1 requests; both are taken one per cycle, back to back.
// Each kind-1 byte walks a chain of MAX_LEN cells, one cell per cycle, so several
// bytes are in flight at once as a diagonal wavefront. A kind-2 (finish) request
// waits until the last byte has left the chain, and is accepted only while the
// output register is free; the result is registered and appears in the cycle
// after the finish is accepted.
// Kind-3 requests are taken and ignored.
`include "assert_macros.svh"

module lcs_length_engine_unit #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [lcsle_pkg::CH_W-1:0]      ch_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lcsle_pkg::LEN_OUT_W-1:0] lcs_length_o,
  output logic [1:0]                     status_o
);
  import lcsle_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned ROW_W   = CNT_W;
  localparam int unsigned DRAIN_W = $clog2(MAX_LEN + 2);

  logic [CNT_W-1:0]     sec_cnt_q, sec_cnt_d;
  logic [CNT_W-1:0]     fst_cnt_q, fst_cnt_d;
  logic                 proc_q, proc_d;
  status_e              err_q, err_d;
  logic [DRAIN_W-1:0]   drain_q, drain_d;
  logic [ROW_W-1:0]     last_len_q, last_len_d;
  logic                 head_valid_q;
  logic [CH_W-1:0]      head_ch_q;
  logic                 out_valid_q, out_valid_d;
  logic [LEN_OUT_W-1:0] out_len_q;
  status_e              out_status_q;

  logic       in_accept;
  logic       load;
  logic       step_issue;
  logic       finish;
  cell_ctrl_t cell_ctrl;

  tok_t             chain_tok  [MAX_LEN+1];
  logic [ROW_W-1:0] chain_diag [MAX_LEN+1];
  logic [ROW_W-1:0] chain_left [MAX_LEN+1];

  assign in_ready_o = (kind_i != KIND_FINISH) ||
                      ((drain_q == '0) && (!out_valid_q || out_ready_i));
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    sec_cnt_d  = sec_cnt_q;
    fst_cnt_d  = fst_cnt_q;
    proc_d     = proc_q;
    err_d      = err_q;
    load       = 1'b0;
    step_issue = 1'b0;
    finish     = 1'b0;
    if (in_accept) begin
      case (kind_i)
        KIND_LOAD: begin
          if (proc_q) begin
            if (err_q == ST_OK) err_d = ST_LATE_LOAD;
          end else if (sec_cnt_q >= CNT_W'(MAX_LEN)) begin
            if (err_q == ST_OK) err_d = ST_OVERFLOW;
          end else begin
            load      = 1'b1;
            sec_cnt_d = sec_cnt_q + CNT_W'(1);
          end
        end
        KIND_STEP: begin
          proc_d = 1'b1;
          if (fst_cnt_q >= CNT_W'(MAX_LEN)) begin
            if (err_q == ST_OK) err_d = ST_OVERFLOW;
          end else begin
            step_issue = 1'b1;
            fst_cnt_d  = fst_cnt_q + CNT_W'(1);
          end
        end
        KIND_FINISH: begin
          finish    = 1'b1;
          sec_cnt_d = '0;
          fst_cnt_d = '0;
          proc_d    = 1'b0;
          err_d     = ST_OK;
        end
        default: ;
      endcase
    end
  end

  // Count down until the newest byte has left the last cell.
  always_comb begin
    if (step_issue) begin
      drain_d = DRAIN_W'(MAX_LEN + 1);
    end else if (drain_q != '0) begin
      drain_d = drain_q - DRAIN_W'(1);
    end else begin
      drain_d = drain_q;
    end
  end

  always_comb begin
    if (finish) begin
      last_len_d = '0;
    end else if (chain_tok[MAX_LEN].valid) begin
      last_len_d = chain_left[MAX_LEN];
    end else begin
      last_len_d = last_len_q;
    end
  end

  always_comb begin
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_cnt_q    <= '0;
      fst_cnt_q    <= '0;
      proc_q       <= 1'b0;
      err_q        <= ST_OK;
      drain_q      <= '0;
      last_len_q   <= '0;
      head_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      sec_cnt_q    <= sec_cnt_d;
      fst_cnt_q    <= fst_cnt_d;
      proc_q       <= proc_d;
      err_q        <= err_d;
      drain_q      <= drain_d;
      last_len_q   <= last_len_d;
      head_valid_q <= step_issue;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_ch_q <= ch_i;
    if (finish) begin
      out_len_q    <= LEN_OUT_W'(last_len_q);
      out_status_q <= err_q;
    end
  end

  assign cell_ctrl = '{load: load, clear: finish, ch: ch_i};

  assign chain_tok[0]  = '{valid: head_valid_q, ch: head_ch_q};
  assign chain_diag[0] = '0;
  assign chain_left[0] = '0;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    lcsle_cell #(
      .IDX  (j),
      .CNT_W(CNT_W),
      .ROW_W(ROW_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .count_i(sec_cnt_q),
      .tok_i  (chain_tok[j]),
      .diag_i (chain_diag[j]),
      .left_i (chain_left[j]),
      .tok_o  (chain_tok[j+1]),
      .diag_o (chain_diag[j+1]),
      .left_o (chain_left[j+1])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign lcs_length_o = out_len_q;
  assign status_o     = out_status_q;

  `ASSERT_IMPLY(a_drain_covers_tail, clk_i, rst_ni, chain_tok[MAX_LEN].valid, drain_q != '0, "byte still in chain with drain counter at zero")
  `ASSERT_NEXT(a_error_sticky, clk_i, rst_ni, (err_q != ST_OK) && !finish, err_q == $past(err_q), "latched status changed before finish")
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, (sec_cnt_q <= CNT_W'(MAX_LEN)) && (fst_cnt_q <= CNT_W'(MAX_LEN)), "string count beyond limit")

endmodule

### verif/tb_lcs_length_engine_unit.sv
module tb_lcs_length_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lcsle_pkg::*;

  localparam int unsigned MAX_LEN     = 256;
  localparam logic [1:0]  KIND_NONE   = 2'd3;
  localparam int unsigned HOLD_AFTER  = 12;
  localparam int unsigned HOLD_CYCLES = 900;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]      kind;
    logic [CH_W-1:0] ch;
  } request_t;

  typedef struct packed {
    logic [LEN_OUT_W-1:0] len;
    status_e              status;
  } lcs_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           kind_i = KIND_FINISH;
  logic [CH_W-1:0]      ch_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [LEN_OUT_W-1:0] lcs_length_o;
  logic [1:0]           status_o;

  // Expected DP state of the block.
  logic [CH_W-1:0]      b_chars [MAX_LEN];
  logic [LEN_OUT_W-1:0] dp_row  [MAX_LEN];
  int unsigned          b_len = 0;
  int unsigned          a_len = 0;
  bit                   a_started = 1'b0;
  status_e              pair_status = ST_OK;

  request_t    request_q[$];
  lcs_result_t lcs_expect_q[$];
  lcs_result_t oldest_result;

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 64;
  int unsigned requests_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  lcs_length_engine_unit #(
    .MAX_LEN(MAX_LEN)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .lcs_length_o(lcs_length_o),
    .status_o    (status_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void latch_status(status_e code);
    if (pair_status == ST_OK) pair_status = code;
  endfunction

  task automatic predict_request(request_t r);
    logic [LEN_OUT_W-1:0] diag;
    logic [LEN_OUT_W-1:0] left;
    logic [LEN_OUT_W-1:0] above;
    logic [LEN_OUT_W-1:0] cell_len;
    lcs_result_t          res;
    case (r.kind)
      KIND_LOAD: begin
        // late-load check wins over the length check
        if (a_started) latch_status(ST_LATE_LOAD);
        else if (b_len >= MAX_LEN) latch_status(ST_OVERFLOW);
        else begin
          b_chars[b_len] = r.ch;
          dp_row[b_len]  = '0;
          b_len++;
        end
      end
      KIND_STEP: begin
        a_started = 1'b1;
        if (a_len >= MAX_LEN) begin
          latch_status(ST_OVERFLOW);
        end else begin
          a_len++;
          diag = '0;
          left = '0;
          for (int unsigned j = 0; j < b_len; j++) begin
            above = dp_row[j];
            if (b_chars[j] == r.ch) cell_len = diag + 1'b1;
            else cell_len = (above > left) ? above : left;
            diag      = above;
            dp_row[j] = cell_len;
            left      = cell_len;
          end
        end
      end
      KIND_FINISH: begin
        res.len    = (b_len > 0) ? dp_row[b_len-1] : '0;
        res.status = pair_status;
        lcs_expect_q.push_back(res);
        b_len       = 0;
        a_len       = 0;
        a_started   = 1'b0;
        pair_status = ST_OK;
      end
      default: ;
    endcase
  endtask

  function automatic logic [CH_W-1:0] pick_char(int unsigned alpha);
    logic [CH_W-1:0] c;
    if (alpha == 0) c = CH_W'($urandom_range(2**CH_W - 1));
    else c = CH_W'(8'h61 + $urandom_range(alpha - 1));
    return c;
  endfunction

  task automatic push_request(logic [1:0] k, logic [CH_W-1:0] c);
    request_q.push_back('{kind: k, ch: c});
    if (k != KIND_NONE) requests_queued++;
  endtask

  task automatic queue_pair(int unsigned n_load, int unsigned n_step, int unsigned alpha);
    for (int unsigned i = 0; i < n_load; i++) push_request(KIND_LOAD, pick_char(alpha));
    for (int unsigned i = 0; i < n_step; i++) push_request(KIND_STEP, pick_char(alpha));
    push_request(KIND_FINISH, pick_char(0));
  endtask

  task automatic queue_random_pair();
    int unsigned alpha;
    int unsigned n_load;
    int unsigned n_step;
    int unsigned n_junk;
    alpha = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
    if ($urandom_range(19) == 0) begin
      // broken sequence: any kind in any order
      n_junk = $urandom_range(1, 10);
      for (int unsigned i = 0; i < n_junk; i++) begin
        push_request(2'($urandom_range(3)), pick_char(alpha));
      end
      push_request(KIND_FINISH, pick_char(0));
    end else begin
      n_load = $urandom_range(0, 12);
      n_step = $urandom_range(0, 12);
      for (int unsigned i = 0; i < n_load; i++) begin
        push_request(KIND_LOAD, pick_char(alpha));
        if ($urandom_range(24) == 0) push_request(KIND_NONE, pick_char(0));
      end
      for (int unsigned i = 0; i < n_step; i++) begin
        push_request(KIND_STEP, pick_char(alpha));
        if ($urandom_range(29) == 0) push_request(KIND_LOAD, pick_char(alpha));
        if ($urandom_range(29) == 0) push_request(KIND_NONE, pick_char(0));
      end
      push_request(KIND_FINISH, pick_char(0));
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || lcs_expect_q.size() != 0 || in_valid_i) begin
      @(negedge clk_i);
    end
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_request('{kind: kind_i, ch: ch_i});
      if (!in_valid_i || in_ready_o) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          kind_i     <= request_q[0].kind;
          ch_i       <= request_q[0].ch;
          in_valid_i <= 1'b1;
          void'(request_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (lcs_expect_q.size() == 0) begin
          $error("result with none expected: lcs_length=%0d status=%0d",
                 lcs_length_o, status_o);
          mismatch_count++;
        end else begin
          oldest_result = lcs_expect_q.pop_front();
          if (lcs_length_o !== oldest_result.len) begin
            $error("lcs_length: expected %0d, got %0d", oldest_result.len, lcs_length_o);
            mismatch_count++;
          end
          if (status_o !== oldest_result.status) begin
            $error("status: expected %0d, got %0d", oldest_result.status, status_o);
            mismatch_count++;
          end
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold the result side off once so that the engine backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed pairs: empty pair, ignored kind, byte extremes, late load,
    // one string empty.
    push_request(KIND_FINISH, 8'h00);
    push_request(KIND_NONE, 8'hff);
    push_request(KIND_FINISH, 8'hff);
    push_request(KIND_LOAD, 8'h00);
    push_request(KIND_LOAD, 8'hff);
    push_request(KIND_STEP, 8'hff);
    push_request(KIND_STEP, 8'h00);
    push_request(KIND_FINISH, 8'h00);
    push_request(KIND_LOAD, 8'h61);
    push_request(KIND_LOAD, 8'h62);
    push_request(KIND_LOAD, 8'h63);
    push_request(KIND_STEP, 8'h61);
    push_request(KIND_STEP, 8'h63);
    push_request(KIND_FINISH, 8'h00);
    push_request(KIND_STEP, 8'h78);
    push_request(KIND_LOAD, 8'h78);
    push_request(KIND_FINISH, 8'h00);
    push_request(KIND_LOAD, 8'h71);
    push_request(KIND_LOAD, 8'h72);
    push_request(KIND_FINISH, 8'h00);
    push_request(KIND_STEP, 8'h71);
    push_request(KIND_FINISH, 8'h00);
    while (requests_queued < PHASE_ITEMS) queue_random_pair();
    wait_drained();

    send_idle_pct = 64;
    recv_idle_pct = 12;
    // Late load first, then overflow of the first string: late load must stick.
    push_request(KIND_LOAD, 8'h61);
    push_request(KIND_LOAD, 8'h62);
    push_request(KIND_STEP, 8'h61);
    push_request(KIND_LOAD, 8'h63);
    queue_pair(0, MAX_LEN, 2);
    while (requests_queued < 2 * PHASE_ITEMS) queue_random_pair();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Full-length strings that match everywhere, second two bytes and first one byte
    // too long, then a late load: largest length, and the overflow must stick.
    for (int unsigned i = 0; i < MAX_LEN + 2; i++) push_request(KIND_LOAD, 8'h7a);
    for (int unsigned i = 0; i < MAX_LEN + 1; i++) push_request(KIND_STEP, 8'h7a);
    push_request(KIND_LOAD, 8'h7a);
    push_request(KIND_FINISH, 8'h00);
    while (requests_queued < 3 * PHASE_ITEMS) queue_random_pair();
    wait_drained();

    repeat (MAX_LEN + 16) @(negedge clk_i);
    if (mismatch_count == 0 && lcs_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### lcs_length_engine_unit.f
+incdir+src
src/lcsle_pkg.sv
src/lcsle_cell.sv
src/lcs_length_engine_unit.sv
verif/tb_lcs_length_engine_unit.sv
